// ----- rtl/isa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// isa_pkg: shared definitions for the indexed shift array
// Sizes, operation and status codes, and the per-cell command type.
// ----------------------------------------------------------------------------
package isa_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_INSERT = 3'd2;
    localparam logic [2:0] MODE_ERASE  = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;
    localparam logic [2:0] MODE_CLEAR  = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_RANGE = 2'd3;

    typedef logic [WORD_WIDTH-1:0] word_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LOWER,
        CELL_FROM_UPPER,
        CELL_ZERO
    } cell_op_t;

endpackage
`default_nettype wire

// ----- rtl/isa_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// isa_cell: one storage slot of the shift array
// Holds one word; loads a new word, takes a neighbor's word or clears.
// ----------------------------------------------------------------------------
module isa_cell (
    input  wire               clk,
    input  wire               rst_n,
    input  isa_pkg::cell_op_t op,
    input  isa_pkg::word_t    load_word,
    input  isa_pkg::word_t    lower_word,
    input  isa_pkg::word_t    upper_word,
    output isa_pkg::word_t    word
);
    import isa_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        case (op)
            CELL_HOLD:       word_next = word_reg;
            CELL_LOAD:       word_next = load_word;
            CELL_FROM_LOWER: word_next = lower_word;
            CELL_FROM_UPPER: word_next = upper_word;
            CELL_ZERO:       word_next = '0;
            default:         word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule
`default_nettype wire

// ----- rtl/indexed_shift_array.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_shift_array: fixed-capacity ordered array of signed words
// Append, remove last, insert, erase, read and clear over a row of cells.
// ----------------------------------------------------------------------------
// One operation is taken per clock while busy is low (busy stays low), and its
// result appears with done in the next cycle, for that cycle only. Every cell
// of the row updates in the same edge, so an insert or erase shifts the whole
// tail at once. The receiver cannot stall: done is not held. Failed operations
// report full, empty or bad position and leave the contents unchanged.
module indexed_shift_array (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  [2:0]         mode,
    input  wire  [5:0]         position,
    input  wire  signed [31:0] value,
    output logic               done,
    output logic signed [31:0] read_value,
    output logic [6:0]         count,
    output logic [1:0]         status
);
    import isa_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic signed [31:0] rd_reg;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;

    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_ext;
    logic             full;
    logic             empty;
    logic             take;
    logic             do_append;
    logic             do_remove;
    logic             do_insert;
    logic             do_erase;
    logic             do_read;
    logic             do_clear;

    logic signed [WORD_WIDTH-1:0] load_word;
    logic signed [WORD_WIDTH-1:0] rd_word;
    word_t                        cell_word [DEPTH];
    cell_op_t                     cell_op   [DEPTH];

    assign busy      = 1'b0;
    assign take      = start && !busy;
    assign cnt_ext   = CMP_W'(cnt_reg);
    assign pos_ext   = CMP_W'(position);
    assign full      = (cnt_ext == CMP_W'(DEPTH));
    assign empty     = (cnt_reg == '0);
    assign load_word = WORD_WIDTH'(value);

    always_comb
    begin
        do_append   = 1'b0;
        do_remove   = 1'b0;
        do_insert   = 1'b0;
        do_erase    = 1'b0;
        do_read     = 1'b0;
        do_clear    = 1'b0;
        status_next = STATUS_OK;
        case (mode)
            MODE_APPEND:
            begin
                if (full) status_next = STATUS_FULL;
                else      do_append   = 1'b1;
            end
            MODE_REMOVE:
            begin
                if (empty) status_next = STATUS_EMPTY;
                else       do_remove   = 1'b1;
            end
            MODE_INSERT:
            begin
                if (full)                  status_next = STATUS_FULL;
                else if (pos_ext > cnt_ext) status_next = STATUS_RANGE;
                else                       do_insert   = 1'b1;
            end
            MODE_ERASE:
            begin
                if (empty)                   status_next = STATUS_EMPTY;
                else if (pos_ext >= cnt_ext) status_next = STATUS_RANGE;
                else                         do_erase    = 1'b1;
            end
            MODE_READ:
            begin
                if (empty)                   status_next = STATUS_EMPTY;
                else if (pos_ext >= cnt_ext) status_next = STATUS_RANGE;
                else                         do_read     = 1'b1;
            end
            MODE_CLEAR:
            begin
                do_clear = 1'b1;
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (take)
        begin
            if (do_append || do_insert)     cnt_next = cnt_reg + 1'b1;
            else if (do_remove || do_erase) cnt_next = cnt_reg - 1'b1;
            else if (do_clear)              cnt_next = '0;
        end
    end

    // word select for read: each cell gates its own word onto an or-tree
    always_comb
    begin
        rd_word = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (pos_ext == CMP_W'(k))
                rd_word = rd_word | cell_word[k];
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            localparam logic [CMP_W-1:0] IDX = CMP_W'(g);
            word_t lower;
            word_t upper;

            if (g == 0)
            begin : g_first
                assign lower = '0;
            end
            else
            begin : g_mid_lo
                assign lower = cell_word[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign upper = '0;
            end
            else
            begin : g_mid_hi
                assign upper = cell_word[g+1];
            end

            always_comb
            begin
                cell_op[g] = CELL_HOLD;
                if (take)
                begin
                    if (do_clear)
                        cell_op[g] = CELL_ZERO;
                    else if (do_append && IDX == cnt_ext)
                        cell_op[g] = CELL_LOAD;
                    else if (do_remove && IDX + 1'b1 == cnt_ext)
                        cell_op[g] = CELL_ZERO;
                    else if (do_insert && IDX == pos_ext)
                        cell_op[g] = CELL_LOAD;
                    else if (do_insert && IDX > pos_ext)
                        cell_op[g] = CELL_FROM_LOWER;
                    else if (do_erase && IDX >= pos_ext)
                        cell_op[g] = CELL_FROM_UPPER;
                end
            end

            isa_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (cell_op[g]),
                .load_word  (load_word),
                .lower_word (lower),
                .upper_word (upper),
                .word       (cell_word[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= take;
            if (take)
                status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (do_read) rd_reg <= 32'(rd_word);
            else         rd_reg <= '0;
        end
    end

    logic [CMP_W-1:0] cnt_out;
    assign cnt_out    = CMP_W'(cnt_reg);

    assign done       = done_reg;
    assign read_value = rd_reg;
    assign count      = cnt_out[6:0];
    assign status     = status_reg;

endmodule
`default_nettype wire

// ----- verif/tb_indexed_shift_array.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_shift_array: self-checking regression for the indexed shift array
// A queue-fed driver issues append, remove, insert, erase, read and clear
// transfers with random gaps. A monitor predicts every result from a shadow
// copy of the array and checks each done strobe against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_indexed_shift_array;
    import isa_pkg::*;

    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam int         NUM_RANDOM   = 1200;
    localparam int         MAX_GAP      = 6;

    typedef struct {
        logic [2:0]         mode;
        logic [5:0]         position;
        logic signed [31:0] value;
        int                 gap;
    } array_op_t;

    typedef struct {
        logic signed [31:0] read_value;
        logic [6:0]         count;
        logic [1:0]         status;
    } outcome_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         mode = '0;
    logic [5:0]         position = '0;
    logic signed [31:0] value = '0;
    wire                busy;
    wire                done;
    wire signed [31:0]  read_value;
    wire [6:0]          count;
    wire [1:0]          status;

    array_op_t op_q[$];
    outcome_t  outcome_q[$];
    word_t     shadow_words[DEPTH];
    int        shadow_count;
    int        gen_count;
    bit        gen_quiet;
    int        mismatch_cnt;
    logic      xfer_taken = 1'b0;
    int        gap_left;

    indexed_shift_array uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .position   (position),
        .value      (value),
        .done       (done),
        .read_value (read_value),
        .count      (count),
        .status     (status)
    );

    always #5 clk = ~clk;

    function automatic outcome_t apply_op(input logic [2:0] m, input logic [5:0] p,
                                          input logic signed [31:0] v);
        outcome_t res;
        int       k;
        res.read_value = '0;
        res.status     = STATUS_OK;
        case (m)
            MODE_APPEND:
                if (shadow_count >= DEPTH) res.status = STATUS_FULL;
                else
                begin
                    shadow_words[shadow_count] = word_t'(v);
                    shadow_count++;
                end
            MODE_REMOVE:
                if (shadow_count == 0) res.status = STATUS_EMPTY;
                else
                begin
                    shadow_count--;
                    shadow_words[shadow_count] = '0;
                end
            MODE_INSERT:
                if (shadow_count >= DEPTH) res.status = STATUS_FULL;
                else if (int'(p) > shadow_count) res.status = STATUS_RANGE;
                else
                begin
                    for (k = shadow_count; k > int'(p); k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[p] = word_t'(v);
                    shadow_count++;
                end
            MODE_ERASE:
                if (shadow_count == 0) res.status = STATUS_EMPTY;
                else if (int'(p) >= shadow_count) res.status = STATUS_RANGE;
                else
                begin
                    for (k = int'(p); k + 1 < shadow_count; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_count--;
                    shadow_words[shadow_count] = '0;
                end
            MODE_READ:
                if (shadow_count == 0) res.status = STATUS_EMPTY;
                else if (int'(p) >= shadow_count) res.status = STATUS_RANGE;
                else res.read_value = $signed(shadow_words[p]);
            MODE_CLEAR:
            begin
                for (k = 0; k < DEPTH; k++)
                    shadow_words[k] = '0;
                shadow_count = 0;
            end
            default: ;
        endcase
        res.count = 7'(shadow_count);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_cnt < 50)
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatch_cnt++;
    endtask

    // stimulus side keeps only a running count to aim positions
    task automatic push_op(input logic [2:0] m, input logic [5:0] p,
                           input logic signed [31:0] v);
        array_op_t op;
        op.mode     = m;
        op.position = p;
        op.value    = v;
        op.gap      = gen_quiet ? 0 : $urandom_range(0, MAX_GAP);
        op_q.push_back(op);
        case (m)
            MODE_APPEND: if (gen_count < DEPTH) gen_count++;
            MODE_REMOVE: if (gen_count > 0) gen_count--;
            MODE_INSERT: if (gen_count < DEPTH && int'(p) <= gen_count) gen_count++;
            MODE_ERASE:  if (gen_count > 0 && int'(p) < gen_count) gen_count--;
            MODE_CLEAR:  gen_count = 0;
            default: ;
        endcase
    endtask

    function automatic logic [5:0] pick_position(input bit for_insert);
        int lim;
        lim = for_insert ? gen_count : gen_count - 1;
        if (lim > 63) lim = 63;
        if (lim < 0 || $urandom_range(0, 99) < 20)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, lim));
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_random(input int bias);
        int  roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            push_op(MODE_CLEAR, pick_position(0), pick_value());
        else if (roll < 4)
            push_op(roll[0] ? MODE_SPARE_A : MODE_SPARE_B, 6'($urandom()), $urandom());
        else if (roll < 24)
            push_op(MODE_READ, pick_position(0), pick_value());
        else
        begin
            roll = $urandom_range(0, 99);
            if ((bias == 0 && roll < 80) || (bias == 1 && roll < 20) ||
                (bias == 2 && roll < 50))
            begin
                if (roll[0]) push_op(MODE_APPEND, 6'($urandom()), pick_value());
                else push_op(MODE_INSERT, pick_position(1), pick_value());
            end
            else
            begin
                if (roll[0]) push_op(MODE_REMOVE, 6'($urandom()), pick_value());
                else push_op(MODE_ERASE, pick_position(0), pick_value());
            end
        end
    endtask

    always @(negedge clk)
    begin : driver
        array_op_t op;
        logic      next_start;
        if (rst_n)
        begin
            next_start = start;
            if (start && xfer_taken)
                next_start = 1'b0;
            if (!next_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (op_q.size() > 0)
                begin
                    op = op_q.pop_front();
                    if (op.gap > 0)
                    begin
                        gap_left = op.gap - 1;
                        op_q.push_front(op);
                        op_q[0].gap = 0;
                    end
                    else
                    begin
                        mode       <= op.mode;
                        position   <= op.position;
                        value      <= op.value;
                        next_start = 1'b1;
                    end
                end
            end
            start <= next_start;
        end
    end

    always @(posedge clk)
    begin : monitor
        outcome_t want;
        if (!rst_n)
            xfer_taken <= 1'b0;
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("result with none expected", read_value, '0);
                else
                begin
                    want = outcome_q.pop_front();
                    if (read_value !== want.read_value)
                        report_mismatch("read_value", read_value, want.read_value);
                    if (count !== want.count)
                        report_mismatch("count", 32'(count), 32'(want.count));
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                end
            end
            if (start && !busy)
                outcome_q.push_back(apply_op(mode, position, value));
            xfer_taken <= start && !busy;
        end
    end

    initial
    begin
        #2ms;
        $display("indexed_shift_array regression: fail");
        $finish;
    end

    initial
    begin : main
        int k;
        int phase_len;
        int bias;
        bit first;
        mismatch_cnt = 0;
        shadow_count = 0;
        gen_count    = 0;
        gap_left     = 0;
        gen_quiet    = 1'b0;
        for (k = 0; k < DEPTH; k++)
            shadow_words[k] = '0;

        // empty-array errors, word extremes, insert and erase edges, spare modes
        push_op(MODE_READ,   6'd0,  '0);
        push_op(MODE_REMOVE, 6'd0,  '0);
        push_op(MODE_ERASE,  6'd0,  '0);
        push_op(MODE_APPEND, 6'd0,  32'sh7fff_ffff);
        push_op(MODE_APPEND, 6'd63, 32'sh8000_0000);
        push_op(MODE_APPEND, 6'd0,  '0);
        push_op(MODE_APPEND, 6'd0,  -32'sd1);
        push_op(MODE_INSERT, 6'd0,  32'sh1234_5678);
        push_op(MODE_INSERT, 6'd5,  32'sh5a5a_a5a5);
        push_op(MODE_INSERT, 6'd7,  32'sh0bad_0bad);
        push_op(MODE_READ,   6'd63, '0);
        push_op(MODE_READ,   6'd0,  '0);
        push_op(MODE_READ,   6'd2,  '0);
        push_op(MODE_READ,   6'd5,  '0);
        push_op(MODE_ERASE,  6'd6,  '0);
        push_op(MODE_ERASE,  6'd2,  '0);
        push_op(MODE_ERASE,  6'd4,  '0);
        push_op(MODE_SPARE_A, 6'd63, -32'sd1);
        push_op(MODE_SPARE_B, 6'd0,  '0);
        push_op(MODE_REMOVE, 6'd0,  '0);
        push_op(MODE_CLEAR,  6'd0,  '0);
        push_op(MODE_CLEAR,  6'd63, '0);
        push_op(MODE_READ,   6'd0,  '0);

        // phases of growth, shrinkage and mixed traffic; the first is biased toward growth
        first = 1'b1;
        k = 0;
        while (k < NUM_RANDOM)
        begin
            bias      = first ? 0 : $urandom_range(0, 2);
            phase_len = first ? 100 : $urandom_range(20, 90);
            gen_quiet = !first && ($urandom_range(0, 3) == 0);
            first     = 1'b0;
            repeat (phase_len)
            begin
                push_random(bias);
                k++;
            end
        end
        gen_quiet = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(negedge clk);
        while (op_q.size() != 0 || start || outcome_q.size() != 0);
        repeat (4) @(negedge clk);

        if (mismatch_cnt == 0 && outcome_q.size() == 0)
            $display("indexed_shift_array regression: pass");
        else
            $display("indexed_shift_array regression: fail");
        $finish;
    end

endmodule
